/* src/pmst_pkg.sv */
package pmst_pkg;

	localparam int TABLE_SLOTS = 64;
	localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int ID_W        = 31;
	localparam int FUNC_W      = 2;
	localparam int SLOT_W      = 6;

	localparam logic [FUNC_W-1:0] FUNC_ADD    = FUNC_W'(0);
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = FUNC_W'(1);
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = FUNC_W'(2);

	typedef enum logic [1:0] {
		STAT_FOUND    = 2'd0,
		STAT_DONE     = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_UPDATE
	} pmst_state_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   block_id;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		status_t           status;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic commit;
	} pmst_cmd_t;

	// Index of the lowest set bit; the lowest bit is isolated first so that
	// the index is a plain OR over independent one-hot positions.
	function automatic logic [IDX_W-1:0] lowest_idx(input logic [TABLE_SLOTS-1:0] v);
		logic [TABLE_SLOTS-1:0] oh;
		logic [IDX_W-1:0]       r;
		oh = v & ((~v) + TABLE_SLOTS'(1));
		r  = '0;
		for (int k = 0; k < TABLE_SLOTS; k++) begin
			if (oh[k]) begin
				r = r | IDX_W'(k);
			end
		end
		return r;
	endfunction

endpackage

/* src/pmst_ctrl.sv */
module pmst_ctrl
	import pmst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output pmst_cmd_t cmd
);

	pmst_state_t state_q;
	pmst_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		busy       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_UPDATE: begin
				cmd.commit = 1'b1;
				busy       = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

/* src/pmst_dp.sv */
module pmst_dp
	import pmst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pmst_cmd_t cmd,
	input  req_t      req,
	output logic      done,
	output rsp_t      rsp
);

	logic [ID_W-1:0]        slot_ids_q [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [TABLE_SLOTS-1:0] hit_vec;

	logic [TABLE_SLOTS-1:0] match_s1;
	logic [TABLE_SLOTS-1:0] free_s1;
	logic [FUNC_W-1:0]      func_s1;
	logic [ID_W-1:0]        id_s1;

	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] free_idx;
	logic             has_hit;
	logic             has_free;
	logic             wr_en;
	logic             clr_en;
	rsp_t             rsp_d;
	rsp_t             rsp_q;
	logic             done_q;

	// Every cell compares its own entry against the incoming id.
	always_comb begin
		for (int k = 0; k < TABLE_SLOTS; k++) begin
			hit_vec[k] = valid_q[k] && (slot_ids_q[k] == req.block_id);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			match_s1 <= hit_vec;
			free_s1  <= ~valid_q;
			func_s1  <= req.func;
			id_s1    <= req.block_id;
		end
	end

	assign hit_idx  = lowest_idx(match_s1);
	assign free_idx = lowest_idx(free_s1);
	assign has_hit  = |match_s1;
	assign has_free = |free_s1;

	always_comb begin
		wr_en        = 1'b0;
		clr_en       = 1'b0;
		rsp_d.slot   = '0;
		rsp_d.status = STAT_NOTFOUND;
		priority if (func_s1 == FUNC_ADD) begin
			if (has_hit) begin
				rsp_d.slot   = SLOT_W'(hit_idx);
				rsp_d.status = STAT_FOUND;
			end else if (has_free) begin
				wr_en        = 1'b1;
				rsp_d.slot   = SLOT_W'(free_idx);
				rsp_d.status = STAT_DONE;
			end else begin
				rsp_d.status = STAT_FULL;
			end
		end else if (func_s1 == FUNC_REMOVE) begin
			if (has_hit) begin
				clr_en       = 1'b1;
				rsp_d.slot   = SLOT_W'(hit_idx);
				rsp_d.status = STAT_DONE;
			end
		end else if (func_s1 == FUNC_LOOKUP) begin
			if (has_hit) begin
				rsp_d.slot   = SLOT_W'(hit_idx);
				rsp_d.status = STAT_FOUND;
			end
		end else begin
			rsp_d.status = STAT_NOTFOUND;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			slot_ids_q[free_idx] <= id_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit) begin
			if (wr_en) begin
				valid_q[free_idx] <= 1'b1;
			end else if (clr_en) begin
				valid_q[hit_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* src/position_map_slot_table.sv */
// Position map slot table: a fully associative table of block ids, one
// valid bit per slot, with find-or-allocate, remove and lookup requests.
//
// Request channel: req carries the operation and the block id; a transfer
// takes place at a rising edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle while rsp holds the
// slot and status of one request. The receiver cannot stall it, so each
// result must be taken in the cycle it is shown.
//
// The table compares the id against every slot in the transfer cycle and
// registers the hit and free vectors; the next cycle priority-encodes them
// and updates at most one slot. A new request may transfer in the cycle in
// which the previous result is shown, but not during the update cycle, in
// which busy is high.
//
// Reset clears every valid bit, leaving the table empty, and clears busy
// and done. Slot contents are not reset and are never read while invalid.
module position_map_slot_table
	import pmst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	pmst_cmd_t cmd;

	pmst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	pmst_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	a_update_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("update cycle not followed by a result");

	a_result_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result shown without an update cycle");

	a_transfer_starts_update: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request transfer did not start an update");

	a_fail_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == STAT_FULL || rsp.status == STAT_NOTFOUND))
			|-> (rsp.slot == '0))
		else $error("failed request reports a non-zero slot");

endmodule
